// ===== src/sodc_pkg.sv =====
// Package: widths, types, command codes and fixed-point helpers of the derivative combiner.
`default_nettype none
package sodc_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;
  localparam int PROD_W    = 2 * WORD_BITS;
  localparam int MQ_W      = 2 * WORD_BITS - FRAC_BITS;
  localparam int NUM_W     = MQ_W + 1;
  localparam int NM_W      = NUM_W + FRAC_BITS;
  localparam int SUM_W     = 2 * WORD_BITS + 2;
  localparam int HI_W      = 2 * WORD_BITS - 1 - 2 * FRAC_BITS;

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic signed [PROD_W-1:0]    prod_t;
  typedef logic signed [MQ_W-1:0]      mq_t;
  typedef logic signed [NUM_W-1:0]     num_t;
  typedef logic signed [SUM_W-1:0]     sum_t;

  localparam word_t WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam word_t WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

  typedef enum logic [2:0] {
    CMD_ADD     = 3'd0,
    CMD_SUB     = 3'd1,
    CMD_MUL     = 3'd2,
    CMD_DIV     = 3'd3,
    CMD_COMPOSE = 3'd4,
    CMD_NEGATE  = 3'd5,
    CMD_PASS    = 3'd6
  } cmd_t;

  typedef enum logic {
    LINK_Y  = 1'b0,
    LINK_Y1 = 1'b1
  } link_step_t;

  typedef struct packed {
    logic  [2:0] cmd;
    logic        dz;
    word_t       u;
    word_t       u1;
    word_t       u2;
    word_t       v;
    word_t       v1;
    word_t       v2;
    word_t       y;
    word_t       y1;
    word_t       y2;
    logic        ovf;
    word_t       dy;
    word_t       dy1;
    mq_t         yv2;
    logic        dovf;
  } ctx_t;

  typedef struct packed {
    word_t w;
    logic  o;
  } sat_t;

  // truncating Q product: floor(p / 2^F)
  function automatic mq_t mulq(input prod_t p);
    mulq = p[PROD_W-1:FRAC_BITS];
  endfunction

  function automatic sat_t sat_word(input sum_t x);
    sat_t r;
    if (x > sum_t'(WORD_MAX)) begin
      r.w = WORD_MAX;
      r.o = 1'b1;
    end else if (x < sum_t'(WORD_MIN)) begin
      r.w = WORD_MIN;
      r.o = 1'b1;
    end else begin
      r.w = x[WORD_BITS-1:0];
      r.o = 1'b0;
    end
    sat_word = r;
  endfunction

endpackage
`default_nettype wire

// ===== src/sodc_front.sv =====
// Front pipeline: add, sub, negate, pass, multiply and compose results in three stages.
`default_nettype none
module sodc_front
  import sodc_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  en,
  input  wire logic  in_valid,
  input  wire logic  [2:0] cmd,
  input  wire word_t u,
  input  wire word_t u1,
  input  wire word_t u2,
  input  wire word_t v,
  input  wire word_t v1,
  input  wire word_t v2,
  output logic       out_valid,
  output ctx_t       out_ctx
);

  ctx_t  c1_next, c1, c2, c3_next;
  logic  vld1, vld2;
  sat_t  sa, sb, sc;
  sat_t  ma, mb, mc;

  prod_t p_uv, p_u1v, p_v1u, p_u2v, p_u1v1, p_v2u, p_v1v1, p_v2u1;

  mq_t   m_uv, m_v1u1, m_v2u1;
  sum_t  s_y1, s_y2a, t2;
  logic signed [HI_W+WORD_BITS:0]      p_hi;
  logic signed [FRAC_BITS+WORD_BITS:0] p_lo;
  logic signed [HI_W:0]                hi_s;
  logic signed [FRAC_BITS:0]           lo_s;

  always_comb begin
    c1_next      = '0;
    c1_next.cmd  = cmd;
    c1_next.u    = u;
    c1_next.u1   = u1;
    c1_next.u2   = u2;
    c1_next.v    = v;
    c1_next.v1   = v1;
    c1_next.v2   = v2;
    c1_next.dz   = (cmd == CMD_DIV) && (v == '0);
    c1_next.y    = u;
    c1_next.y1   = u1;
    c1_next.y2   = u2;
    sa = sat_word(sum_t'(u) + sum_t'(v));
    sb = sat_word(sum_t'(u1) + sum_t'(v1));
    sc = sat_word(sum_t'(u2) + sum_t'(v2));
    case (cmd)
      CMD_SUB: begin
        sa = sat_word(sum_t'(u) - sum_t'(v));
        sb = sat_word(sum_t'(u1) - sum_t'(v1));
        sc = sat_word(sum_t'(u2) - sum_t'(v2));
      end
      CMD_NEGATE: begin
        sa = sat_word(-sum_t'(u));
        sb = sat_word(-sum_t'(u1));
        sc = sat_word(-sum_t'(u2));
      end
      default: ;
    endcase
    case (cmd)
      CMD_ADD, CMD_SUB, CMD_NEGATE: begin
        c1_next.y   = sa.w;
        c1_next.y1  = sb.w;
        c1_next.y2  = sc.w;
        c1_next.ovf = sa.o | sb.o | sc.o;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1      <= 1'b0;
      vld2      <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld1      <= in_valid;
      vld2      <= vld1;
      out_valid <= vld2;
    end
  end

  // stage 1: products
  always_ff @(posedge clk) begin
    if (en) begin
      c1     <= c1_next;
      p_uv   <= u * v;
      p_u1v  <= u1 * v;
      p_v1u  <= v1 * u;
      p_u2v  <= u2 * v;
      p_u1v1 <= u1 * v1;
      p_v2u  <= v2 * u;
      p_v1v1 <= v1 * v1;
      p_v2u1 <= v2 * u1;
    end
  end

  // v1*v1 is nonnegative; its Q value is split so the product with u2 stays narrow
  assign hi_s = {1'b0, p_v1v1[PROD_W-2:2*FRAC_BITS]};
  assign lo_s = {1'b0, p_v1v1[2*FRAC_BITS-1:FRAC_BITS]};

  // stage 2: shifts, partial sums, second-level products
  always_ff @(posedge clk) begin
    if (en) begin
      c2     <= c1;
      m_uv   <= mulq(p_uv);
      s_y1   <= sum_t'(mulq(p_u1v)) + sum_t'(mulq(p_v1u));
      s_y2a  <= sum_t'(mulq(p_u2v)) + sum_t'(mulq(p_v2u));
      t2     <= sum_t'(mulq(p_u1v1)) <<< 1;
      m_v1u1 <= mulq(p_u1v1);
      m_v2u1 <= mulq(p_v2u1);
      p_hi   <= hi_s * c1.u2;
      p_lo   <= lo_s * c1.u2;
    end
  end

  always_comb begin
    c3_next = c2;
    ma = sat_word(sum_t'(m_uv));
    mb = sat_word(s_y1);
    mc = sat_word(s_y2a + t2);
    case (c2.cmd)
      CMD_MUL: begin
        c3_next.y   = ma.w;
        c3_next.y1  = mb.w;
        c3_next.y2  = mc.w;
        c3_next.ovf = ma.o | mb.o | mc.o;
      end
      CMD_COMPOSE: begin
        mb = sat_word(sum_t'(m_v1u1));
        mc = sat_word(sum_t'(m_v2u1) + sum_t'(p_hi)
                      + sum_t'($signed(p_lo[FRAC_BITS+WORD_BITS:FRAC_BITS])));
        c3_next.y   = c2.u;
        c3_next.y1  = mb.w;
        c3_next.y2  = mc.w;
        c3_next.ovf = mb.o | mc.o;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_ctx <= c3_next;
    end
  end

endmodule
`default_nettype wire

// ===== src/sodc_div.sv =====
// Pipelined restoring divider: saturated Q quotient (num << F) / v, one bit per stage.
`default_nettype none
module sodc_div
  import sodc_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  en,
  input  wire logic  in_valid,
  input  wire ctx_t  in_ctx,
  input  wire num_t  num,
  output logic       out_valid,
  output ctx_t       out_ctx,
  output word_t      q,
  output logic       q_ovf
);

  logic [NUM_W-1:0]          amag;
  logic [NM_W-1:0]           nmag;
  logic [NM_W-WORD_BITS-1:0] high;
  logic [WORD_BITS-1:0]      mv;
  logic                      neg0, big0;

  logic [WORD_BITS-1:0] st_rem [0:WORD_BITS];
  logic [WORD_BITS-1:0] st_n   [0:WORD_BITS];
  logic [WORD_BITS-1:0] st_q   [0:WORD_BITS];
  logic [WORD_BITS-1:0] st_mv  [0:WORD_BITS];
  logic                 st_neg [0:WORD_BITS];
  logic                 st_big [0:WORD_BITS];
  ctx_t                 st_ctx [0:WORD_BITS];
  logic                 st_vld [0:WORD_BITS];

  logic [WORD_BITS:0] t_a [1:WORD_BITS];
  logic [WORD_BITS:0] d_a [1:WORD_BITS];
  logic               ge_a [1:WORD_BITS];

  logic [WORD_BITS-1:0] qm;
  word_t                q_next;
  logic                 ovf_next;

  always_comb begin
    amag = num[NUM_W-1] ? (~num + 1'b1) : num;
    nmag = {amag, {FRAC_BITS{1'b0}}};
    high = nmag[NM_W-1:WORD_BITS];
    mv   = in_ctx.v[WORD_BITS-1] ? (~in_ctx.v + 1'b1) : in_ctx.v;
    neg0 = num[NUM_W-1] ^ in_ctx.v[WORD_BITS-1];
    big0 = high >= (NM_W-WORD_BITS)'(mv);
  end

  always_comb begin
    for (int i = 1; i <= WORD_BITS; i++) begin
      t_a[i]  = {st_rem[i-1], st_n[i-1][WORD_BITS-1]};
      d_a[i]  = t_a[i] - {1'b0, st_mv[i-1]};
      ge_a[i] = t_a[i] >= {1'b0, st_mv[i-1]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= WORD_BITS; i++) st_vld[i] <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      st_vld[0] <= in_valid;
      for (int i = 1; i <= WORD_BITS; i++) st_vld[i] <= st_vld[i-1];
      out_valid <= st_vld[WORD_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_rem[0] <= high[WORD_BITS-1:0];
      st_n[0]   <= nmag[WORD_BITS-1:0];
      st_q[0]   <= '0;
      st_mv[0]  <= mv;
      st_neg[0] <= neg0;
      st_big[0] <= big0;
      st_ctx[0] <= in_ctx;
      for (int i = 1; i <= WORD_BITS; i++) begin
        st_rem[i] <= ge_a[i] ? d_a[i][WORD_BITS-1:0] : t_a[i][WORD_BITS-1:0];
        st_n[i]   <= st_n[i-1] << 1;
        st_q[i]   <= {st_q[i-1][WORD_BITS-2:0], ge_a[i]};
        st_mv[i]  <= st_mv[i-1];
        st_neg[i] <= st_neg[i-1];
        st_big[i] <= st_big[i-1];
        st_ctx[i] <= st_ctx[i-1];
      end
    end
  end

  // sign and clamp to the word range
  always_comb begin
    qm       = st_q[WORD_BITS];
    q_next   = st_neg[WORD_BITS] ? WORD_MIN : WORD_MAX;
    ovf_next = 1'b1;
    if (!st_big[WORD_BITS]) begin
      if (st_neg[WORD_BITS]) begin
        if (qm <= WORD_MIN) begin
          q_next   = ~qm + 1'b1;
          ovf_next = 1'b0;
        end
      end else if (qm <= WORD_MAX) begin
        q_next   = qm;
        ovf_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_ctx <= st_ctx[WORD_BITS];
      q       <= q_next;
      q_ovf   <= ovf_next;
    end
  end

endmodule
`default_nettype wire

// ===== src/sodc_link.sv =====
// Link between divides: stores a quotient and forms the next quotient-rule dividend.
`default_nettype none
module sodc_link
  import sodc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       en,
  input  wire link_step_t step,
  input  wire logic       in_valid,
  input  wire ctx_t       in_ctx,
  input  wire word_t      q,
  input  wire logic       q_ovf,
  output logic            out_valid,
  output ctx_t            out_ctx,
  output num_t            out_num
);

  ctx_t  ca_next, ca, cb_next;
  logic  vld_a;
  prod_t pa, pb;
  num_t  num_next;
  mq_t   ma;

  always_comb begin
    ca_next      = in_ctx;
    ca_next.dovf = in_ctx.dovf | q_ovf;
    case (step)
      LINK_Y:  ca_next.dy  = q;
      LINK_Y1: ca_next.dy1 = q;
      default: ca_next.dy  = q;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_a     <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld_a     <= in_valid;
      out_valid <= vld_a;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ca <= ca_next;
      pa <= q * in_ctx.v1;
      pb <= q * in_ctx.v2;
    end
  end

  always_comb begin
    cb_next  = ca;
    ma       = mulq(pa);
    num_next = num_t'(ca.u1) - num_t'(ma);
    case (step)
      LINK_Y: cb_next.yv2 = mulq(pb);
      LINK_Y1: num_next = num_t'(ca.u2) - (num_t'(ma) <<< 1) - num_t'(ca.yv2);
      default: cb_next.yv2 = mulq(pb);
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_ctx <= cb_next;
      out_num <= num_next;
    end
  end

endmodule
`default_nettype wire

// ===== src/second_order_derivative_combine_unit.sv =====
// Combines two (value, d1, d2) Q16.16 triples by second-order forward differentiation rules.
// Input channel s_*: one transaction carries a command in s_tuser and both operand
// triples in s_tdata. Output channel m_*: one transaction carries the result triple in
// m_tdata and the overflow and divide-by-zero flags in m_tuser.
// Every input transaction yields exactly one output transaction, in order.
// The pipeline is the same for every command: 3 front stages (products, sums, clamps),
// three 34-stage dividers (one quotient bit per stage, 32 bits each), two 2-stage
// links between them, and the output register. Divide needs its three quotients in
// series, which sets the depth; all commands share the same path.
// Throughput is one transaction per cycle while the receiver does not stall.
// The whole pipeline advances when the output register is empty or being taken;
// when the receiver stalls, every stage holds and s_tready drops, so nothing is lost.
// Bubbles stay in place while stalled.
// Reset (rst, synchronous) clears all valid bits; no output is shown until new input.
`default_nettype none
module second_order_derivative_combine_unit
  import sodc_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [191:0] s_tdata,  // u_val, u_d1, u_d2, v_val, v_d1, v_d2
  input  wire logic [2:0]   s_tuser,  // command
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [95:0]       m_tdata,  // y_val, y_d1, y_d2
  output logic [1:0]        m_tuser   // overflow, div_zero
);

  logic en;
  logic f_vld, d1_vld, l1_vld, d2_vld, l2_vld, d3_vld;
  ctx_t f_ctx, d1_ctx, l1_ctx, d2_ctx, l2_ctx, d3_ctx;
  num_t l1_num, l2_num;
  word_t q1, q2, q3;
  logic  o1, o2, o3;
  word_t y_n, y1_n, y2_n;
  logic  ovf_n, dz_n;

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  sodc_front u_front (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(s_tvalid && s_tready),
    .cmd(s_tuser),
    .u($signed(s_tdata[31:0])),
    .u1($signed(s_tdata[63:32])),
    .u2($signed(s_tdata[95:64])),
    .v($signed(s_tdata[127:96])),
    .v1($signed(s_tdata[159:128])),
    .v2($signed(s_tdata[191:160])),
    .out_valid(f_vld), .out_ctx(f_ctx)
  );

  sodc_div u_div_y (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(f_vld), .in_ctx(f_ctx), .num(num_t'(f_ctx.u)),
    .out_valid(d1_vld), .out_ctx(d1_ctx), .q(q1), .q_ovf(o1)
  );

  sodc_link u_link_y (
    .clk(clk), .rst(rst), .en(en), .step(LINK_Y),
    .in_valid(d1_vld), .in_ctx(d1_ctx), .q(q1), .q_ovf(o1),
    .out_valid(l1_vld), .out_ctx(l1_ctx), .out_num(l1_num)
  );

  sodc_div u_div_y1 (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(l1_vld), .in_ctx(l1_ctx), .num(l1_num),
    .out_valid(d2_vld), .out_ctx(d2_ctx), .q(q2), .q_ovf(o2)
  );

  sodc_link u_link_y1 (
    .clk(clk), .rst(rst), .en(en), .step(LINK_Y1),
    .in_valid(d2_vld), .in_ctx(d2_ctx), .q(q2), .q_ovf(o2),
    .out_valid(l2_vld), .out_ctx(l2_ctx), .out_num(l2_num)
  );

  sodc_div u_div_y2 (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(l2_vld), .in_ctx(l2_ctx), .num(l2_num),
    .out_valid(d3_vld), .out_ctx(d3_ctx), .q(q3), .q_ovf(o3)
  );

  always_comb begin
    y_n   = d3_ctx.y;
    y1_n  = d3_ctx.y1;
    y2_n  = d3_ctx.y2;
    ovf_n = d3_ctx.ovf;
    dz_n  = 1'b0;
    if (d3_ctx.cmd == CMD_DIV) begin
      if (d3_ctx.dz) begin
        y_n   = d3_ctx.u[WORD_BITS-1] ? WORD_MIN : WORD_MAX;
        y1_n  = y_n;
        y2_n  = y_n;
        ovf_n = 1'b1;
        dz_n  = 1'b1;
      end else begin
        y_n   = d3_ctx.dy;
        y1_n  = d3_ctx.dy1;
        y2_n  = q3;
        ovf_n = d3_ctx.dovf | o3;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= d3_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= {y2_n, y1_n, y_n};
      m_tuser <= {dz_n, ovf_n};
    end
  end

`ifndef SYNTH
  a_dz_ovf: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (!m_tuser[1] || m_tuser[0]))
    else $error("div_zero without overflow");

  a_dz_fill: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[1]) |-> (m_tdata[31:0] == m_tdata[63:32]
                                  && m_tdata[63:32] == m_tdata[95:64]))
    else $error("divide by zero result fields differ");

  a_rst_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");
`endif

endmodule
`default_nettype wire
